### sv/dense_layer_matvec_bias_defines.svh
// assertion macros for the dense layer block
// used by the top level only, no other dependencies
`ifndef DENSE_LAYER_MATVEC_BIAS_DEFINES_SVH
`define DENSE_LAYER_MATVEC_BIAS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DLMVB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DLMVB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dlmvb_pkg.sv
// shared constants, opcodes and controller/datapath interface structs
// for the dense layer block; no dependencies
`timescale 1ns / 1ps

package dlmvb_pkg;

    localparam int MAX_IN    = 16;
    localparam int MAX_OUT   = 16;
    localparam int DATA_W    = 16;
    localparam int ACC_W     = 32;
    localparam int SCALE_W   = 16;
    localparam int CNT_W     = 5;
    localparam int IN_IDX_W  = $clog2(MAX_IN);
    localparam int OUT_IDX_W = $clog2(MAX_OUT);
    localparam int W_DEPTH   = MAX_IN * MAX_OUT;
    localparam int W_ADDR_W  = $clog2(W_DEPTH);
    localparam int OP_W      = 2;
    localparam int IDX_W     = 8;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(ACC_W + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_BIAS   = 2'd1,
        OP_LOAD_INPUT  = 2'd2,
        OP_START       = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

    typedef struct packed {
        logic load;
        logic start;
        logic row_init;
        logic mac_issue;
        logic round;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic ni_zero;
        logic no_zero;
        logic col_last;
        logic row_last;
        logic mac_busy;
        logic div_busy;
        logic out_busy;
    } status_t;

endpackage

### sv/dense_layer_matvec_bias.sv
// load items (weight, bias, input element) are accepted back to back while idle; a start
// works through each output row in turn: ni mac issues, a mac drain,
// rounding, and the one-bit-per-cycle divider, which sets the pace
// synchronous active-low reset clears the controller, counters, output valid and
// restores the registers to 16 inputs, 16 outputs, divisor 256; stores are not cleared
`timescale 1ns / 1ps

`include "dense_layer_matvec_bias_defines.svh"

module dense_layer_matvec_bias (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [dlmvb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dlmvb_pkg::SCALE_W-1:0]     cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation [1:0], index [9:2], value [25:10], zero pad [31:26]
    input  logic [dlmvb_pkg::S_TDATA_W-1:0]   s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_value [15:0], row_index [19:16], zero pad [23:20]
    output logic [dlmvb_pkg::M_TDATA_W-1:0]   m_tdata,
    // last_row: final row of a start
    output logic                              m_tlast
);
    import dlmvb_pkg::*;

    cmd_t    cmd;
    status_t status;
    op_t     op;

    // opcode sits in the low bits of every input transfer
    assign op = op_t'(s_tdata[OP_W-1:0]);

    // controller: accepts one item at a time and steps through the rows
    dlmvb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (op),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: stores, mac, rounding divider and the output register that
    // lets the next input transfer in while a result still waits
    dlmvb_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // a result is only loaded into a free output register
    `DLMVB_ASSERT_NOW(a_out_load_free, aclk, aresetn, cmd.out_load, !status.out_busy, "result loaded over a pending transfer")

    // a result is emitted only once the mac pipeline and divider are quiet
    `DLMVB_ASSERT_NOW(a_out_load_done, aclk, aresetn, cmd.out_load, !status.mac_busy && !status.div_busy, "result emitted before row work finished")

    // starting the divider makes it busy in the next cycle
    `DLMVB_ASSERT_NEXT(a_div_runs, aclk, aresetn, cmd.div_start, status.div_busy, "divider did not start")

    // the block takes input only with no row work in flight
    `DLMVB_ASSERT_NOW(a_ready_quiet, aclk, aresetn, s_tready, !status.mac_busy && !status.div_busy, "input ready during row work")

endmodule

### sv/dlmvb_div.sv
// restoring divider, one quotient bit per cycle
// depends on dlmvb_pkg
`timescale 1ns / 1ps

module dlmvb_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dlmvb_pkg::ACC_W-1:0]   dividend,
    input  logic [dlmvb_pkg::SCALE_W-1:0] divisor,
    output logic                          busy,
    output logic [dlmvb_pkg::ACC_W-1:0]   quotient
);
    import dlmvb_pkg::*;

    logic [ACC_W-1:0]     quot_reg;
    logic [SCALE_W-1:0]   rem_reg;
    logic [SCALE_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SCALE_W:0]     shifted;
    logic                 fits;

    assign shifted = {rem_reg, quot_reg[ACC_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign busy     = cnt_reg != '0;
    assign quotient = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= DIV_CNT_W'(ACC_W);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy) begin
            if (fits) begin
                rem_reg <= SCALE_W'(shifted - {1'b0, dvs_reg});
            end else begin
                rem_reg <= shifted[SCALE_W-1:0];
            end
            quot_reg <= {quot_reg[ACC_W-2:0], fits};
        end
    end

endmodule

### sv/dlmvb_ctrl.sv
// controller state machine: sequences loads, row setup, mac, rounding,
// division and result hand-off; depends on dlmvb_pkg
`timescale 1ns / 1ps

module dlmvb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  dlmvb_pkg::op_t        op,
    output logic                  s_tready,
    input  dlmvb_pkg::status_t    status,
    output dlmvb_pkg::cmd_t       cmd
);
    import dlmvb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_INIT,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (op == OP_START) begin
                        cmd.start = 1'b1;
                        if (!status.no_zero) begin
                            state_next = ST_ROW_INIT;
                        end
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_ROW_INIT: begin
                cmd.row_init = 1'b1;
                state_next   = status.ni_zero ? ST_DRAIN : ST_MAC;
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                if (status.col_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.mac_busy) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.row_last ? ST_IDLE : ST_ROW_INIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/dlmvb_datapath.sv
// datapath: config registers, weight/bias/input stores, mac pipeline,
// rounding, divider and output register; depends on dlmvb_pkg, dlmvb_div
`timescale 1ns / 1ps

module dlmvb_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [dlmvb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dlmvb_pkg::SCALE_W-1:0]     cfg_wdata,
    input  logic [dlmvb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  dlmvb_pkg::cmd_t                   cmd,
    output dlmvb_pkg::status_t                status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dlmvb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import dlmvb_pkg::*;

    // effective (saturated) configuration
    logic [CNT_W-1:0]   ni_reg;
    logic [CNT_W-1:0]   no_reg;
    logic [SCALE_W-1:0] div_reg;
    logic [CNT_W-1:0]   cfg_cnt;
    logic [CNT_W-1:0]   cfg_cnt_sat;

    // stores
    logic [DATA_W-1:0] weight_mem [W_DEPTH];
    logic [DATA_W-1:0] bias_mem   [MAX_OUT];
    logic [DATA_W-1:0] input_mem  [MAX_IN];

    // input payload
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;

    // counters
    logic [OUT_IDX_W-1:0] row_reg;
    logic [IN_IDX_W-1:0]  col_reg;
    logic [W_ADDR_W-1:0]  base_reg;
    logic [W_ADDR_W-1:0]  rd_addr;

    // mac pipeline
    logic [DATA_W-1:0]          w_rd_reg;
    logic [DATA_W-1:0]          x_rd_reg;
    logic                       v1_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       v2_reg;
    logic [ACC_W-1:0]           acc_reg;

    // rounding and division
    logic [ACC_W-1:0]   rnd_reg;
    logic               neg_reg;
    logic [ACC_W-1:0]   mag;
    logic               div_busy;
    logic [ACC_W-1:0]   quot;
    logic [DATA_W-1:0]  res;

    // output register
    logic                 m_tvalid_reg;
    logic [DATA_W-1:0]    res_reg;
    logic [OUT_IDX_W-1:0] row_out_reg;
    logic                 last_out_reg;

    assign op  = op_t'(s_tdata[OP_W-1:0]);
    assign idx = s_tdata[OP_W +: IDX_W];
    assign val = s_tdata[OP_W+IDX_W +: DATA_W];

    assign cfg_cnt     = cfg_wdata[CNT_W-1:0];
    assign cfg_cnt_sat = (cfg_cnt > CNT_W'(MAX_IN)) ? CNT_W'(MAX_IN) : cfg_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ni_reg  <= CNT_W'(MAX_IN);
            no_reg  <= CNT_W'(MAX_OUT);
            div_reg <= SCALE_W'(256);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INPUTS:  ni_reg  <= cfg_cnt_sat;
                CFG_OUTPUTS: no_reg  <= (cfg_cnt > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : cfg_cnt;
                CFG_SCALE:   div_reg <= (cfg_wdata == '0) ? SCALE_W'(1) : cfg_wdata;
                default:     ;
            endcase
        end
    end

    assign rd_addr = base_reg + W_ADDR_W'(col_reg);

    // weight store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.load && op == OP_LOAD_WEIGHT) begin
            weight_mem[idx[W_ADDR_W-1:0]] <= val;
        end
        if (cmd.mac_issue) begin
            w_rd_reg <= weight_mem[rd_addr];
        end
    end

    // input vector, registered read
    always_ff @(posedge aclk) begin
        if (cmd.load && op == OP_LOAD_INPUT && idx < IDX_W'(MAX_IN)) begin
            input_mem[idx[IN_IDX_W-1:0]] <= val;
        end
        if (cmd.mac_issue) begin
            x_rd_reg <= input_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && op == OP_LOAD_BIAS && idx < IDX_W'(MAX_OUT)) begin
            bias_mem[idx[OUT_IDX_W-1:0]] <= val;
        end
    end

    // row and column counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            base_reg <= '0;
        end else begin
            if (cmd.start) begin
                row_reg  <= '0;
                base_reg <= '0;
            end else if (cmd.out_load) begin
                row_reg  <= row_reg + 1'b1;
                base_reg <= base_reg + W_ADDR_W'(ni_reg);
            end
            if (cmd.row_init) begin
                col_reg <= '0;
            end else if (cmd.mac_issue) begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // mac pipeline: bias term on row setup, then read, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
            if (cmd.row_init) begin
                acc_reg <= ACC_W'($signed(bias_mem[row_reg]) * $signed({1'b0, div_reg}));
            end else if (v2_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            prod_reg <= $signed(w_rd_reg) * $signed(x_rd_reg);
        end
    end

    // round by half the divisor, then split sign and magnitude
    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            rnd_reg <= acc_reg + ACC_W'(div_reg >> 1);
        end
        if (cmd.div_start) begin
            neg_reg <= rnd_reg[ACC_W-1];
        end
    end

    assign mag = rnd_reg[ACC_W-1] ? (~rnd_reg + 1'b1) : rnd_reg;

    dlmvb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (mag),
        .divisor  (div_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign res = neg_reg ? (~quot[DATA_W-1:0] + 1'b1) : quot[DATA_W-1:0];

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_reg      <= res;
            row_out_reg  <= row_reg;
            last_out_reg <= status.row_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-DATA_W-OUT_IDX_W){1'b0}}, row_out_reg, res_reg};
    assign m_tlast  = last_out_reg;

    assign status.ni_zero  = ni_reg == '0;
    assign status.no_zero  = no_reg == '0;
    assign status.col_last = {1'b0, col_reg} == CNT_W'(ni_reg - 1'b1);
    assign status.row_last = {1'b0, row_reg} == CNT_W'(no_reg - 1'b1);
    assign status.mac_busy = v1_reg || v2_reg;
    assign status.div_busy = div_busy;
    assign status.out_busy = m_tvalid_reg && !m_tready;

endmodule

### dv/tb_top.sv
// self-checking testbench for the dense_layer_matvec_bias quantized dense layer
// a directed stimulus table is followed by randomized phases; each row result is checked
// against a typed row or a matrix-vector-bias predictor kept here; depends on dlmvb_pkg, rtl
`timescale 1ns / 1ps

module tb_top;
    import dlmvb_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int TOTAL_ITEMS     = 280;
    localparam int CLOSING_ITEMS   = 40;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int HOLD_CYCLES     = 2500;
    localparam int PAD_W           = S_TDATA_W - OP_W - IDX_W - DATA_W;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCALE_W-1:0]   cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // operation, index, value, zero pad
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // result_value, row_index, zero pad
    logic                 m_tlast;   // last_row

    dense_layer_matvec_bias u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // one expected row result
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [3:0]        row;
        logic              last;
    } row_result_t;

    // directed stimulus: either a register write or one input transfer
    typedef enum logic {
        STIM_CFG,
        STIM_ITEM
    } stim_kind_t;

    typedef struct packed {
        stim_kind_t           kind;
        op_t                  op;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [IDX_W-1:0]     idx;
        logic [DATA_W-1:0]    val;
        logic                 typed;      // expected row typed in below
        logic [DATA_W-1:0]    typed_val;
    } stim_row_t;

    stim_row_t   stim_rows[$];
    row_result_t pending_rows[$];
    row_result_t head_row;

    // predictor copy of the stores and registers
    logic signed [DATA_W-1:0] weight_mem [W_DEPTH];
    logic signed [DATA_W-1:0] bias_mem   [MAX_OUT];
    logic signed [DATA_W-1:0] act_mem    [MAX_IN];
    bit                       weight_set [W_DEPTH];
    bit                       bias_set   [MAX_OUT];
    bit                       act_set    [MAX_IN];
    logic [CNT_W-1:0]         ni_reg;
    logic [CNT_W-1:0]         no_reg;
    logic [SCALE_W-1:0]       div_reg;

    int err_count   = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int hold_req    = 0;
    bit idle_en     = 1'b1;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake or a missing row ends here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic flag_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    function automatic row_result_t make_row(logic [DATA_W-1:0] value, int row, bit last);
        row_result_t res;
        res.value = value;
        res.row   = 4'(row);
        res.last  = last;
        return res;
    endfunction

    // counts above the store size saturate
    function automatic int used_inputs();
        return (ni_reg > MAX_IN) ? MAX_IN : int'(ni_reg);
    endfunction

    function automatic int used_outputs();
        return (no_reg > MAX_OUT) ? MAX_OUT : int'(no_reg);
    endfunction

    // applies one accepted transfer; a start queues one row result per output in use
    function automatic void predict_layer(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        int               n_in;
        int               n_out;
        int               d;
        int               r;
        int               c;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] quo;
        case (op)
            OP_LOAD_WEIGHT: begin
                weight_mem[idx] = val;
                weight_set[idx] = 1'b1;
            end
            OP_LOAD_BIAS: begin
                // out-of-range index is dropped
                if (idx < MAX_OUT) begin
                    bias_mem[idx] = val;
                    bias_set[idx] = 1'b1;
                end
            end
            OP_LOAD_INPUT: begin
                if (idx < MAX_IN) begin
                    act_mem[idx] = val;
                    act_set[idx] = 1'b1;
                end
            end
            default: begin
                n_in  = used_inputs();
                n_out = used_outputs();
                d     = (div_reg == 0) ? 1 : int'(div_reg);   // zero divisor acts as one
                for (r = 0; r < n_out; r++) begin
                    acc = ACC_W'(longint'(bias_mem[r]) * longint'(d));
                    for (c = 0; c < n_in; c++)
                        acc = acc + ACC_W'(longint'(act_mem[c]) * longint'(weight_mem[r*n_in+c]));
                    // add half the divisor, then divide the magnitude toward zero
                    acc = acc + ACC_W'(d / 2);
                    mag = acc[ACC_W-1] ? -acc : acc;
                    quo = mag / ACC_W'(d);
                    if (acc[ACC_W-1])
                        quo = -quo;
                    pending_rows.push_back(make_row(quo[DATA_W-1:0], r, r == n_out - 1));
                end
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // row/column count, upper write bits sometimes junk
    function automatic logic [SCALE_W-1:0] pick_count();
        int v;
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 1;
            2:       v = 16;
            3:       v = $urandom_range(17, 31);
            default: v = $urandom_range(1, 16);
        endcase
        if ($urandom_range(0, 1))
            return {11'($urandom), 5'(v)};
        return SCALE_W'(v);
    endfunction

    function automatic logic [SCALE_W-1:0] pick_divisor();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd2;
            3:       return 16'hFFFF;
            4:       return SCALE_W'($urandom_range(3, 1024));
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    // one input transfer, with an optional idle burst ahead of it
    task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                             logic typed, logic [DATA_W-1:0] typed_val);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, val, idx, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (op == OP_START && typed)
            pending_rows.push_back(make_row(typed_val, 0, 1'b1));
        else
            predict_layer(op, idx, val);
    endtask

    // load every store entry the next start will read that was never written
    task automatic fill_unwritten();
        int n_in;
        int n_out;
        int r;
        int c;
        n_in  = used_inputs();
        n_out = used_outputs();
        for (r = 0; r < n_out; r++) begin
            if (!bias_set[r])
                send_item(OP_LOAD_BIAS, IDX_W'(r), random_value(), 1'b0, '0);
            for (c = 0; c < n_in; c++)
                if (!weight_set[r*n_in+c])
                    send_item(OP_LOAD_WEIGHT, IDX_W'(r*n_in+c), random_value(), 1'b0, '0);
        end
        if (n_out != 0)
            for (c = 0; c < n_in; c++)
                if (!act_set[c])
                    send_item(OP_LOAD_INPUT, IDX_W'(c), random_value(), 1'b0, '0);
    endtask

    task automatic wait_results_done();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
    endtask

    // a zero-output start leaves no row to wait for, so settle afterwards too
    task automatic wait_drained();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [SCALE_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= data;
        case (sel)
            CFG_INPUTS:  ni_reg  = data[CNT_W-1:0];
            CFG_OUTPUTS: no_reg  = data[CNT_W-1:0];
            CFG_SCALE:   div_reg = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] sel, logic [SCALE_W-1:0] data);
        stim_row_t s;
        s           = '0;
        s.kind      = STIM_CFG;
        s.reg_sel   = sel;
        s.val       = data;
        stim_rows.push_back(s);
    endtask

    task automatic add_item(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                            logic typed, logic [DATA_W-1:0] typed_val);
        stim_row_t s;
        s           = '0;
        s.kind      = STIM_ITEM;
        s.op        = op;
        s.idx       = idx;
        s.val       = val;
        s.typed     = typed;
        s.typed_val = typed_val;
        stim_rows.push_back(s);
    endtask

    // result side: random not-ready bursts, plus a long hold when one is requested
    initial begin
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (burst_left != 0) begin
                burst_left--;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker: each transfer against the oldest pending row
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rows.size() == 0) begin
                flag_mismatch("unexpected row result, row_index", m_tdata[DATA_W+3:DATA_W], -1);
            end else begin
                head_row = pending_rows.pop_front();
                if (m_tdata[DATA_W-1:0] !== head_row.value)
                    flag_mismatch("result_value", $signed(m_tdata[DATA_W-1:0]),
                                  $signed(head_row.value));
                if (m_tdata[DATA_W+3:DATA_W] !== head_row.row)
                    flag_mismatch("row_index", m_tdata[DATA_W+3:DATA_W], head_row.row);
                if (m_tlast !== head_row.last)
                    flag_mismatch("last_row", m_tlast, head_row.last);
            end
        end
    end

    // main sequence
    initial begin
        int   p;
        int   n;
        int   kind;
        bit   dirty;
        op_t  op;
        logic [IDX_W-1:0] idx;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_INPUTS;
        cfg_wdata <= '0;
        ni_reg    = 5'd16;
        no_reg    = 5'd16;
        div_reg   = 16'd256;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // bias only: no inputs, one row, divisor one
        add_cfg(CFG_INPUTS, 16'd0);
        add_cfg(CFG_OUTPUTS, 16'd1);
        add_cfg(CFG_SCALE, 16'd1);
        add_item(OP_LOAD_BIAS, 8'd0, 16'd7, 1'b0, '0);
        add_item(OP_START, 8'd0, 16'd0, 1'b1, 16'd7);
        add_item(OP_LOAD_BIAS, 8'd0, 16'h8000, 1'b0, '0);
        add_item(OP_START, 8'd0, 16'd0, 1'b1, 16'h8000);
        // zero divisor behaves as one
        add_item(OP_LOAD_BIAS, 8'd0, 16'h7FFF, 1'b0, '0);
        add_cfg(CFG_SCALE, 16'd0);
        add_item(OP_START, 8'd0, 16'd0, 1'b1, 16'h7FFF);
        // out-of-range bias and input loads are dropped; start ignores index and value
        add_item(OP_LOAD_BIAS, 8'hFF, 16'h1234, 1'b0, '0);
        add_item(OP_LOAD_INPUT, 8'h10, 16'h5555, 1'b0, '0);
        add_item(OP_START, 8'hFF, 16'hFFFF, 1'b1, 16'h7FFF);
        // zero outputs: start gives no row
        add_cfg(CFG_OUTPUTS, 16'd0);
        add_item(OP_START, 8'd0, 16'd0, 1'b0, '0);
        // single product at the most negative values, result wraps
        add_cfg(CFG_INPUTS, 16'd1);
        add_cfg(CFG_OUTPUTS, 16'd1);
        add_cfg(CFG_SCALE, 16'd1);
        add_item(OP_LOAD_INPUT, 8'd0, 16'h8000, 1'b0, '0);
        add_item(OP_LOAD_WEIGHT, 8'd0, 16'h8000, 1'b0, '0);
        add_item(OP_START, 8'd0, 16'd0, 1'b0, '0);
        // inputs above sixteen saturate, largest divisor
        add_cfg(CFG_INPUTS, 16'hFFFF);
        add_cfg(CFG_OUTPUTS, 16'd1);
        add_cfg(CFG_SCALE, 16'hFFFF);
        add_item(OP_LOAD_WEIGHT, 8'd15, 16'h7FFF, 1'b0, '0);
        add_item(OP_LOAD_INPUT, 8'd15, 16'h8000, 1'b0, '0);
        add_item(OP_START, 8'd0, 16'd0, 1'b0, '0);
        // outputs above sixteen saturate, bias term only
        add_cfg(CFG_INPUTS, 16'd0);
        add_cfg(CFG_OUTPUTS, 16'd20);
        add_cfg(CFG_SCALE, 16'd2);
        add_item(OP_LOAD_BIAS, 8'd15, 16'h8000, 1'b0, '0);
        add_item(OP_START, 8'd0, 16'd0, 1'b0, '0);

        dirty = 1'b0;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == STIM_CFG) begin
                if (dirty) begin
                    wait_drained();
                    dirty = 1'b0;
                end
                write_reg(stim_rows[i].reg_sel, stim_rows[i].val);
            end else begin
                if (stim_rows[i].op == OP_START)
                    fill_unwritten();
                send_item(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].val,
                          stim_rows[i].typed, stim_rows[i].typed_val);
                dirty = 1'b1;
            end
        end

        // random phases, each with a fresh register setting
        p = 0;
        while (items_sent < TOTAL_ITEMS) begin
            wait_drained();
            if (p == 0) begin
                // two inputs, all sixteen rows, while the result side holds off
                write_reg(CFG_INPUTS, 16'd2);
                write_reg(CFG_OUTPUTS, 16'd16);
            end else begin
                write_reg(CFG_INPUTS, pick_count());
                write_reg(CFG_OUTPUTS, pick_count());
            end
            write_reg(CFG_SCALE, pick_divisor());
            if (p == 0)
                hold_req = HOLD_CYCLES;
            n = 0;
            while (n < ITEMS_PER_PHASE && items_sent < TOTAL_ITEMS) begin
                // no idling in the closing stretch, and none every fourth phase
                idle_en = (items_sent < TOTAL_ITEMS - CLOSING_ITEMS) && (p % 4 != 3);
                // sender waits out every pending row midway through the second phase
                if (p == 1 && n == ITEMS_PER_PHASE / 2)
                    wait_results_done();
                kind = $urandom_range(0, 9);
                if (kind < 2) begin
                    fill_unwritten();
                    send_item(OP_START, IDX_W'($urandom), DATA_W'($urandom), 1'b0, '0);
                    n++;
                end else if (kind == 2) begin
                    // dropped load, not counted in the phase
                    op = $urandom_range(0, 1) ? OP_LOAD_BIAS : OP_LOAD_INPUT;
                    send_item(op, IDX_W'($urandom_range(MAX_OUT, 255)), random_value(), 1'b0, '0);
                end else begin
                    case ($urandom_range(0, 2))
                        0: begin
                            op = OP_LOAD_WEIGHT;
                            if ($urandom_range(0, 3) != 0 && used_inputs() * used_outputs() != 0)
                                idx = IDX_W'($urandom_range(0, used_inputs() * used_outputs() - 1));
                            else
                                idx = IDX_W'($urandom);
                        end
                        1: begin
                            op  = OP_LOAD_BIAS;
                            idx = IDX_W'($urandom_range(0, MAX_OUT - 1));
                        end
                        default: begin
                            op  = OP_LOAD_INPUT;
                            idx = IDX_W'($urandom_range(0, MAX_IN - 1));
                        end
                    endcase
                    send_item(op, idx, random_value(), 1'b0, '0);
                    n++;
                end
            end
            p++;
        end

        wait_drained();
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### dense_layer_matvec_bias.f
+incdir+sv
sv/dlmvb_pkg.sv
sv/dlmvb_div.sv
sv/dlmvb_ctrl.sv
sv/dlmvb_datapath.sv
sv/dense_layer_matvec_bias.sv
dv/tb_top.sv
